// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/iso2jp_pkg.sv -----
// ----------------------------------------------------------------------------
// iso2jp_pkg
// types, constants and the per-byte decode function of the ISO-2022-JP decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iso2jp_pkg;

  localparam logic [7:0]  ESC_BYTE    = 8'h1b;
  localparam logic [15:0] KANA_BASE   = 16'hff61;
  localparam logic [7:0]  KANA_LOW    = 8'ha1;
  localparam logic [7:0]  KANA_HIGH   = 8'hdf;
  localparam logic [7:0]  JIS_LOW     = 8'h21;
  localparam logic [7:0]  JIS_HIGH    = 8'h7e;
  localparam logic [15:0] REPLACEMENT = 16'hfffd;

  localparam logic [7:0] INTRO_1BYTE = 8'h28;
  localparam logic [7:0] INTRO_2BYTE = 8'h24;
  localparam logic [7:0] FINAL_ASCII = 8'h42;
  localparam logic [7:0] FINAL_KANA  = 8'h49;
  localparam logic [7:0] FINAL_JIS78 = 8'h40;
  localparam logic [7:0] FINAL_JIS83 = 8'h42;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    CS_ASCII = 4'b0001,
    CS_KANA  = 4'b0010,
    CS_JIS78 = 4'b0100,
    CS_JIS83 = 4'b1000
  } charset_e;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_HELD = 3'b100
  } esc_stage_e;

  typedef enum logic {
    KIND_UNICODE = 1'b0,
    KIND_JIS     = 1'b1
  } code_kind_e;

  typedef struct packed {
    logic [15:0] value;
    logic        kind;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] value;
    logic        kind;
    logic        lead_p;
    logic [7:0]  lead_b;
    logic        esc_start;
  } plain_res_t;

  function automatic logic in_jis(input logic [7:0] b);
    return (b >= JIS_LOW) && (b <= JIS_HIGH);
  endfunction

  // decode one byte with no escape pending
  function automatic plain_res_t decode_plain(input charset_e cs, input logic lead_p,
                                              input logic [7:0] lead_b, input logic [7:0] x,
                                              input logic last);
    plain_res_t r;
    r = '0;
    r.lead_b = lead_b;
    if (lead_p) begin
      r.emit = 1'b1;
      if (in_jis(lead_b) && in_jis(x)) begin
        r.value = {lead_b, x};
        r.kind  = KIND_JIS;
      end else begin
        r.value = REPLACEMENT;
        r.kind  = KIND_UNICODE;
      end
    end else if (x == ESC_BYTE) begin
      r.esc_start = !last;
    end else if (cs == CS_ASCII) begin
      r.emit  = 1'b1;
      r.kind  = KIND_UNICODE;
      r.value = x[7] ? REPLACEMENT : {8'h00, x};
    end else if (cs == CS_KANA) begin
      r.emit = 1'b1;
      r.kind = KIND_UNICODE;
      if ((x >= KANA_LOW) && (x <= KANA_HIGH)) begin
        r.value = KANA_BASE + {8'h00, x} - {8'h00, KANA_LOW};
      end else begin
        r.value = REPLACEMENT;
      end
    end else begin
      if (last) begin
        r.emit  = 1'b1;
        r.kind  = KIND_UNICODE;
        r.value = REPLACEMENT;
      end else begin
        r.lead_p = 1'b1;
        r.lead_b = x;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/iso2022jp_stream_decoder_core.sv -----
// Latency: a beat's results enter the output queue at the accepting edge and show
// on the output from the next cycle on.
// Throughput: one input beat per cycle while the four-entry output queue holds at
// most two results; a beat yields at most two results.
// Reset: async active-low; charset goes to ASCII, no escape or lead byte pending,
// output queue empty. End of stream clears the same state but for the queue.
// ----------------------------------------------------------------------------
// iso2022jp_stream_decoder_core
// ISO-2022-JP byte decoder with charset tracking and a small result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iso2022jp_stream_decoder_core
  import iso2jp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_value_o,
  output logic        code_kind_o,
  output logic        run_last_o
);

  charset_e   cs_q, cs_d;
  esc_stage_e esc_q, esc_d;
  logic [7:0] held_q, held_d;
  logic       lead_q, lead_d;
  logic [7:0] lead_b_q, lead_b_d;

  res_t             fifo_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  logic       in_fire, out_fire;
  logic       last;
  logic [7:0] first_byte;
  logic       matched;
  charset_e   match_cs;
  plain_res_t r1, r2;
  logic       emit0, emit1;
  res_t       res0, res1;
  res_t       push_a, push_b;
  logic [1:0] push_n;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign last     = end_of_stream_i;

  assign in_ready_o  = (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign code_value_o = fifo_q[rd_ptr_q].value;
  assign code_kind_o  = fifo_q[rd_ptr_q].kind;
  assign run_last_o   = fifo_q[rd_ptr_q].last;

  // escape sequence match
  always_comb begin
    matched  = 1'b1;
    match_cs = CS_ASCII;
    if ((held_q == INTRO_1BYTE) && (in_byte_i == FINAL_ASCII)) begin
      match_cs = CS_ASCII;
    end else if ((held_q == INTRO_1BYTE) && (in_byte_i == FINAL_KANA)) begin
      match_cs = CS_KANA;
    end else if ((held_q == INTRO_2BYTE) && (in_byte_i == FINAL_JIS78)) begin
      match_cs = CS_JIS78;
    end else if ((held_q == INTRO_2BYTE) && (in_byte_i == FINAL_JIS83)) begin
      match_cs = CS_JIS83;
    end else begin
      matched = 1'b0;
    end
  end

  // first pass decodes the held byte on a failed escape, else the new byte
  assign first_byte = (esc_q == ESC_HELD) ? held_q : in_byte_i;
  assign r1 = decode_plain(cs_q, lead_q, lead_b_q, first_byte,
                           (esc_q == ESC_HELD) ? 1'b0 : last);
  assign r2 = decode_plain(cs_q, r1.lead_p, r1.lead_b, in_byte_i, last);

  always_comb begin
    cs_d     = cs_q;
    esc_d    = esc_q;
    held_d   = held_q;
    lead_d   = lead_q;
    lead_b_d = lead_b_q;
    emit0    = 1'b0;
    emit1    = 1'b0;
    res0     = '{value: r1.value, kind: r1.kind, last: 1'b1};
    res1     = '{value: r2.value, kind: r2.kind, last: 1'b1};
    unique case (esc_q)
      ESC_NONE: begin
        emit0    = r1.emit;
        lead_d   = r1.lead_p;
        lead_b_d = r1.lead_b;
        esc_d    = r1.esc_start ? ESC_SEEN : ESC_NONE;
      end
      ESC_SEEN: begin
        if (last) begin
          emit0 = r1.emit;
          esc_d = ESC_NONE;
        end else begin
          held_d = in_byte_i;
          esc_d  = ESC_HELD;
        end
      end
      ESC_HELD: begin
        if (matched) begin
          cs_d  = match_cs;
          esc_d = ESC_NONE;
        end else if (r1.esc_start && !last) begin
          held_d = in_byte_i;
          esc_d  = ESC_HELD;
        end else begin
          emit0    = r1.emit;
          emit1    = r2.emit;
          lead_d   = r2.lead_p;
          lead_b_d = r2.lead_b;
          esc_d    = r2.esc_start ? ESC_SEEN : ESC_NONE;
        end
      end
      default: begin
        esc_d = ESC_NONE;
      end
    endcase
    if (last) begin
      cs_d     = CS_ASCII;
      esc_d    = ESC_NONE;
      held_d   = '0;
      lead_d   = 1'b0;
      lead_b_d = '0;
    end
    res0.last = !emit1;
  end

  // compact the up to two results of a beat
  always_comb begin
    push_a = emit0 ? res0 : res1;
    push_b = res1;
    push_n = in_fire ? (2'(emit0) + 2'(emit1)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= CS_ASCII;
      esc_q    <= ESC_NONE;
      held_q   <= '0;
      lead_q   <= 1'b0;
      lead_b_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        cs_q     <= cs_d;
        esc_q    <= esc_d;
        held_q   <= held_d;
        lead_q   <= lead_d;
        lead_b_q <= lead_b_d;
      end
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= push_b;
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "result queue overflow")
  `ASSERT_ALWAYS(a_lead_esc_excl, !(lead_q && (esc_q != ESC_NONE)),
                 "lead byte and escape pending together")
  `ASSERT_NEXT(a_eos_reset, in_fire && end_of_stream_i,
               (cs_q == CS_ASCII) && (esc_q == ESC_NONE) && !lead_q,
               "state not cleared after end of stream")
  `ASSERT_NEXT(a_count_step, in_fire && !out_fire,
               cnt_q >= $past(cnt_q), "queue count dropped without a pop")

endmodule

// ----- bench/iso2022jp_stream_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// iso2022jp_stream_decoder_core_tb
// drives ISO-2022-JP byte streams into the decoder, predicts every code unit
// from a behavioral copy of the charset and escape tracking, and checks each
// output beat in order under random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iso2022jp_stream_decoder_core_tb;
  import iso2jp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 920;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_AFTER   = 250;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned MAX_GAP      = 18;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       wait_drain;
  } stream_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_value_o;
  logic        code_kind_o;
  logic        run_last_o;

  iso2022jp_stream_decoder_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_value_o    (code_value_o),
    .code_kind_o     (code_kind_o),
    .run_last_o      (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stream_byte_t pending_bytes[$];
  res_t         expected_codes[$];
  res_t         step_codes[$];

  // decoder state as predicted
  charset_e   cs_now;
  esc_stage_e esc_now;
  logic [7:0] esc_held;
  logic       lead_wait;
  logic [7:0] lead_val;

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  int  codes_seen = 0;
  bit  byte_taken = 1'b0;
  bit  code_taken = 1'b0;

  function automatic bit jis_byte(input logic [7:0] b);
    return (b >= JIS_LOW) && (b <= JIS_HIGH);
  endfunction

  task automatic clear_decoder();
    cs_now    = CS_ASCII;
    esc_now   = ESC_NONE;
    esc_held  = 8'h00;
    lead_wait = 1'b0;
    lead_val  = 8'h00;
  endtask

  task automatic push_code(input logic [15:0] value, input code_kind_e kind);
    res_t r;
    r.value = value;
    r.kind  = kind;
    r.last  = 1'b0;
    step_codes.insert(step_codes.size(), r);
  endtask

  // one byte with no escape sequence in progress
  task automatic decode_simple(input logic [7:0] b, input logic eos);
    if (lead_wait) begin
      lead_wait = 1'b0;
      if (jis_byte(lead_val) && jis_byte(b)) begin
        push_code({lead_val, b}, KIND_JIS);
      end else begin
        push_code(REPLACEMENT, KIND_UNICODE);
      end
    end else if (b == ESC_BYTE) begin
      if (!eos) esc_now = ESC_SEEN;
    end else begin
      case (cs_now)
        CS_ASCII: begin
          push_code(b[7] ? REPLACEMENT : {8'h00, b}, KIND_UNICODE);
        end
        CS_KANA: begin
          if (b >= KANA_LOW && b <= KANA_HIGH) begin
            push_code(KANA_BASE + 16'(b - KANA_LOW), KIND_UNICODE);
          end else begin
            push_code(REPLACEMENT, KIND_UNICODE);
          end
        end
        default: begin
          if (eos) begin
            push_code(REPLACEMENT, KIND_UNICODE);
          end else begin
            lead_wait = 1'b1;
            lead_val  = b;
          end
        end
      endcase
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    logic [7:0] held;
    res_t       r;
    step_codes.delete();
    if (lead_wait) begin
      decode_simple(b, eos);
    end else if (esc_now == ESC_SEEN) begin
      if (eos) begin
        esc_now = ESC_NONE;
        decode_simple(b, 1'b1);
      end else begin
        esc_held = b;
        esc_now  = ESC_HELD;
      end
    end else if (esc_now == ESC_HELD) begin
      held    = esc_held;
      esc_now = ESC_NONE;
      if (held == INTRO_1BYTE && b == FINAL_ASCII) begin
        cs_now = CS_ASCII;
      end else if (held == INTRO_1BYTE && b == FINAL_KANA) begin
        cs_now = CS_KANA;
      end else if (held == INTRO_2BYTE && b == FINAL_JIS78) begin
        cs_now = CS_JIS78;
      end else if (held == INTRO_2BYTE && b == FINAL_JIS83) begin
        cs_now = CS_JIS83;
      end else begin
        // unmatched escape: replay the held byte, then this one, or hold this one if the held byte opened a new escape
        decode_simple(held, 1'b0);
        if (esc_now == ESC_SEEN && !eos) begin
          esc_held = b;
          esc_now  = ESC_HELD;
        end else begin
          esc_now = ESC_NONE;
          decode_simple(b, eos);
        end
      end
    end else begin
      decode_simple(b, eos);
    end
    if (eos) clear_decoder();
    for (int k = 0; k < step_codes.size(); k++) begin
      r = step_codes[k];
      r.last = (k == step_codes.size() - 1);
      expected_codes.insert(expected_codes.size(), r);
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eos);
    stream_byte_t s;
    s.data       = b;
    s.eos        = eos;
    s.wait_drain = 1'b0;
    pending_bytes.insert(pending_bytes.size(), s);
  endtask

  task automatic add_escape(input int unsigned charset_sel);
    add_byte(ESC_BYTE, 1'b0);
    case (charset_sel)
      0: begin add_byte(INTRO_1BYTE, 1'b0); add_byte(FINAL_ASCII, 1'b0); end
      1: begin add_byte(INTRO_1BYTE, 1'b0); add_byte(FINAL_KANA, 1'b0); end
      2: begin add_byte(INTRO_2BYTE, 1'b0); add_byte(FINAL_JIS78, 1'b0); end
      default: begin add_byte(INTRO_2BYTE, 1'b0); add_byte(FINAL_JIS83, 1'b0); end
    endcase
  endtask

  // input side
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;
  always @(negedge clk_i) begin
    logic next_valid;
    stream_byte_t s;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && byte_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].wait_drain && expected_codes.size() != 0)) begin
          s = pending_bytes.pop_front();
          in_byte_i       <= s.data;
          end_of_stream_i <= s.eos;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // output side
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          recv_burst = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (code_taken) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!hold_done && codes_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // beat monitor and checker
  always @(posedge clk_i) begin
    res_t e;
    byte_taken = 1'b0;
    code_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        byte_taken = 1'b1;
        predict_byte(in_byte_i, end_of_stream_i);
      end
      if (out_valid_o && out_ready_i) begin
        code_taken = 1'b1;
        codes_seen++;
        if (expected_codes.size() == 0) begin
          $error("unexpected beat: code_value %h code_kind %b run_last %b",
                 code_value_o, code_kind_o, run_last_o);
          mismatch_count++;
        end else begin
          e = expected_codes.pop_front();
          if (code_value_o !== e.value) begin
            $error("code_value: expected %h, got %h", e.value, code_value_o);
            mismatch_count++;
          end
          if (code_kind_o !== e.kind) begin
            $error("code_kind: expected %b, got %b", e.kind, code_kind_o);
            mismatch_count++;
          end
          if (run_last_o !== e.last) begin
            $error("run_last: expected %b, got %b", e.last, run_last_o);
            mismatch_count++;
          end
        end
      end
      idle_cycles = (byte_taken || code_taken) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned sel;
    int unsigned n;
    int unsigned cs;
    clear_decoder();

    // directed: field extremes, each charset, pairing and escape corner cases
    add_byte(8'h00, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'hff, 1'b0);
    add_escape(1);
    add_byte(KANA_LOW, 1'b0);
    add_byte(KANA_HIGH, 1'b0);
    add_byte(8'h80, 1'b0);
    add_escape(2);
    add_byte(JIS_LOW, 1'b0);
    add_byte(JIS_HIGH, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'h21, 1'b0);
    add_byte(8'h30, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_escape(3);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(INTRO_1BYTE, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h45, 1'b1);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h42, 1'b1);
    add_byte(ESC_BYTE, 1'b1);
    pending_bytes[pending_bytes.size() - 1].wait_drain = 1'b1;

    // random: mostly well-formed charset runs, some noise and broken escapes
    while (pending_bytes.size() < RANDOM_BYTES) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        cs = $urandom_range(0, 3);
        add_escape(cs);
        n = $urandom_range(1, 10);
        repeat (n) begin
          case (cs)
            0: add_byte(8'($urandom_range(0, 127)), 1'b0);
            1: add_byte(8'($urandom_range(KANA_LOW, KANA_HIGH)), 1'b0);
            default: begin
              add_byte(8'($urandom_range(JIS_LOW, JIS_HIGH)), 1'b0);
              add_byte(8'($urandom_range(JIS_LOW, JIS_HIGH)), 1'b0);
            end
          endcase
        end
      end else if (sel == 7) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel == 8) begin
        add_byte(ESC_BYTE, 1'b0);
        add_byte($urandom_range(0, 1) ? ESC_BYTE : 8'($urandom_range(0, 255)), 1'b0);
        add_byte($urandom_range(0, 1) ? INTRO_1BYTE : 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        if ($urandom_range(0, 2) == 0) add_byte(ESC_BYTE, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    pending_bytes[pending_bytes.size() / 2].wait_drain = 1'b1;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_codes.size() != 0) begin
      $error("%0d expected beats never arrived", expected_codes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/iso2jp_pkg.sv
rtl/core/iso2022jp_stream_decoder_core.sv
bench/iso2022jp_stream_decoder_core_tb.sv
